// ===== rtl/core/lfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared command codes and configuration constants of the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // request command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // capacity register
  localparam int unsigned CAP_BITS = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: valid/ready handshake with a get/set beat.
// ----------------------------------------------------------------------------
interface lfu_req_if #(
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [KEY_BITS-1:0]  key;
  logic [DATA_BITS-1:0] write_value;

  modport source (output valid, command, key, write_value, input ready);
  modport sink   (input valid, command, key, write_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfu_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Result channel: valid/ready handshake with one result beat per request.
// ----------------------------------------------------------------------------
interface lfu_rsp_if #(
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DATA_BITS-1:0] read_value;
  logic                 evicted;
  logic [KEY_BITS-1:0]  evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfu_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_mem
// Simple dual-port entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfu_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Scan sequencer: lookup and victim search over resident entries, rank
// compaction after an eviction, write-back and result register.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int DATA_BITS  = 32,
  parameter int COUNT_BITS = 32,
  parameter int IW         = $clog2(ENTRIES),
  parameter int CW         = $clog2(ENTRIES + 1),
  parameter int WW         = KEY_BITS + DATA_BITS + COUNT_BITS + IW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clear,
  input  wire logic [CAP_BITS-1:0] capacity,
  lfu_req_if.sink                  in_req,
  lfu_rsp_if.source                out_rsp,
  output logic      [IW-1:0]       rd_addr,
  input  wire logic [WW-1:0]       rd_data,
  output logic                     wr_en,
  output logic      [IW-1:0]       wr_addr,
  output logic      [WW-1:0]       wr_data,
  output logic      [CW-1:0]       res_count
);

  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  typedef enum logic [2:0] {IDLE, SCAN, DECIDE, RANK, DONE} state_t;

  state_t                state_r;
  logic [CW-1:0]         rc_r;
  logic [CW-1:0]         idx_r;
  logic                  v_r;
  logic [IW-1:0]         vaddr_r;
  logic                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [DATA_BITS-1:0]  wval_r;
  logic                  found_r;
  logic [IW-1:0]         fidx_r;
  logic [DATA_BITS-1:0]  fdata_r;
  logic [COUNT_BITS-1:0] fcnt_r;
  logic [IW-1:0]         frank_r;
  logic                  have_r;
  logic [IW-1:0]         vic_r;
  logic [COUNT_BITS-1:0] min_cnt_r;
  logic [IW-1:0]         min_rank_r;
  logic [KEY_BITS-1:0]   vic_key_r;
  logic                  hit_r;
  logic [DATA_BITS-1:0]  rval_r;
  logic                  ev_r;
  logic [KEY_BITS-1:0]   ekey_r;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_BITS-1:0]  out_rval_r;
  logic                  out_ev_r;
  logic [KEY_BITS-1:0]   out_ekey_r;

  logic [IW-1:0]         e_rank;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [DATA_BITS-1:0]  e_data;
  logic [KEY_BITS-1:0]   e_key;
  logic                  full;
  logic                  evict_self;
  logic                  more;
  logic [COUNT_BITS-1:0] cnt_bump;

  // unpack the word read last cycle
  assign e_rank = rd_data[IW-1:0];
  assign e_cnt  = rd_data[IW +: COUNT_BITS];
  assign e_data = rd_data[IW + COUNT_BITS +: DATA_BITS];
  assign e_key  = rd_data[IW + COUNT_BITS + DATA_BITS +: KEY_BITS];

  // store is full at min(capacity, ENTRIES) residents
  assign full = (CMPW'(rc_r) >= CMPW'(capacity)) || (rc_r == CW'(ENTRIES));
  assign evict_self = !have_r || (min_cnt_r > COUNT_BITS'(1));
  assign more = idx_r < rc_r;
  assign cnt_bump = (fcnt_r == '1) ? fcnt_r : fcnt_r + COUNT_BITS'(1);

  assign rd_addr   = idx_r[IW-1:0];
  assign res_count = rc_r;

  assign in_req.ready        = (state_r == IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.read_value  = out_rval_r;
  assign out_rsp.evicted     = out_ev_r;
  assign out_rsp.evicted_key = out_ekey_r;

  // write-back: hit update, insert, rank compaction, victim refill
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_r)
      DECIDE: begin
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = fidx_r;
          wr_data = {key_r, (cmd_r == CMD_SET) ? wval_r : fdata_r, cnt_bump, frank_r};
        end else if (cmd_r == CMD_SET && !full) begin
          wr_en   = 1'b1;
          wr_addr = rc_r[IW-1:0];
          wr_data = {key_r, wval_r, COUNT_BITS'(1), rc_r[IW-1:0]};
        end
      end
      RANK: begin
        if (v_r) begin
          if (e_rank > min_rank_r) begin
            wr_en   = 1'b1;
            wr_addr = vaddr_r;
            wr_data = {e_key, e_data, e_cnt, e_rank - IW'(1)};
          end
        end else if (!more) begin
          wr_en   = 1'b1;
          wr_addr = vic_r;
          wr_data = {key_r, wval_r, COUNT_BITS'(1), IW'(rc_r - CW'(1))};
        end
      end
      default: ;
    endcase
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      rc_r        <= '0;
      idx_r       <= '0;
      v_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear) begin
        rc_r <= '0;
      end
      if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_req.valid) begin
            cmd_r   <= in_req.command;
            key_r   <= in_req.key;
            wval_r  <= in_req.write_value;
            idx_r   <= '0;
            v_r     <= 1'b0;
            found_r <= 1'b0;
            have_r  <= 1'b0;
            state_r <= SCAN;
          end
        end
        SCAN, RANK: begin
          // issue the next read, track the one in flight
          if (more) begin
            v_r     <= 1'b1;
            vaddr_r <= idx_r[IW-1:0];
            idx_r   <= idx_r + CW'(1);
          end else begin
            v_r <= 1'b0;
          end
          if (state_r == SCAN && v_r) begin
            if (e_key == key_r) begin
              found_r <= 1'b1;
              fidx_r  <= vaddr_r;
              fdata_r <= e_data;
              fcnt_r  <= e_cnt;
              frank_r <= e_rank;
            end
            if (!have_r || e_cnt < min_cnt_r ||
                (e_cnt == min_cnt_r && e_rank < min_rank_r)) begin
              have_r     <= 1'b1;
              vic_r      <= vaddr_r;
              min_cnt_r  <= e_cnt;
              min_rank_r <= e_rank;
              vic_key_r  <= e_key;
            end
          end
          if (!more && !v_r) begin
            state_r <= (state_r == SCAN) ? DECIDE : DONE;
          end
        end
        DECIDE: begin
          hit_r   <= found_r;
          rval_r  <= (found_r && cmd_r == CMD_GET) ? fdata_r : '0;
          ev_r    <= 1'b0;
          ekey_r  <= '0;
          state_r <= DONE;
          if (!found_r && cmd_r == CMD_SET) begin
            if (full) begin
              ev_r <= 1'b1;
              if (evict_self) begin
                ekey_r <= key_r;
              end else begin
                ekey_r  <= vic_key_r;
                idx_r   <= '0;
                v_r     <= 1'b0;
                state_r <= RANK;
              end
            end else begin
              rc_r <= rc_r + CW'(1);
            end
          end
        end
        DONE: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_r;
            out_rval_r  <= rval_r;
            out_ev_r    <= ev_r;
            out_ekey_r  <= ekey_r;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfu_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_key_value_cache_unit
// Fully associative key/value cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  in_req   | in  | command, key, write_value
//  out_rsp  | out | hit, read_value, evicted, evicted_key
//  cfg      | in  | capacity write (cfg_we, cfg_wdata)
//
//  A request scans the residents with one memory read per cycle. A set that
//  evicts a resident adds a rank pass over the residents. Resets clear the
//  resident count; no clearing pass. Writing capacity empties the store. A
//  stalled result waits in the output register while the next request is
//  taken.
// ----------------------------------------------------------------------------
module lfu_key_value_cache_unit
  import lfu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int DATA_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  lfu_req_if.sink                  in_req,
  lfu_rsp_if.source                out_rsp,
  input  wire logic                cfg_we,
  input  wire logic [CAP_BITS-1:0] cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = KEY_BITS + DATA_BITS + COUNT_BITS + IW;

  logic [CAP_BITS-1:0] capacity_r;
  logic [IW-1:0]       rd_addr;
  logic [WW-1:0]       rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [WW-1:0]       wr_data;
  logic [CW-1:0]       res_count;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  lfu_mem #(.DEPTH(ENTRIES), .WIDTH(WW)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lfu_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .DATA_BITS  (DATA_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .capacity  (capacity_r),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_count (res_count)
  );

  // resident count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_count <= CW'(ENTRIES))
    else $error("resident count above store size");

  // writes land only on resident slots or the next free one
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) <= res_count))
    else $error("memory write beyond resident range");

  // no memory write while a new beat is taken
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !(in_req.valid && in_req.ready))
    else $error("memory write during request accept");

  // an accepted request holds off the next one
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while busy");

endmodule

`default_nettype wire

// ===== verif/tb_lfu_key_value_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_key_value_cache_unit
// Drives get/set beats into the LFU cache under several capacities, predicts
// hit, read value and eviction for every request, and checks each result beat.
// ----------------------------------------------------------------------------
module tb_lfu_key_value_cache_unit;
  import lfu_pkg::*;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lfu_result_t;

  // Tracks cache contents and the queue of predicted result beats
  class lfu_scoreboard;
    bit          used[SLOTS];
    logic [31:0] keys[SLOTS];
    logic [31:0] data[SLOTS];
    logic [31:0] uses[SLOTS];
    int          rank[SLOTS];
    int          residents;
    int          capacity;
    int          errors;
    lfu_result_t awaited[$];

    function void set_capacity(int cap);
      capacity = cap;
      residents = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Predict the result of one accepted request and update the contents
    function void note_request(logic cmd, logic [31:0] k, logic [31:0] v);
      lfu_result_t r;
      int found, victim, slot, cap;
      found = -1;
      victim = -1;
      slot = -1;
      cap = (capacity > SLOTS) ? SLOTS : capacity;
      r = '{1'b0, 32'd0, 1'b0, 32'd0};
      for (int i = 0; i < SLOTS; i++)
        if (found < 0 && used[i] && keys[i] == k) found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        if (uses[found] != COUNT_MAX) uses[found] = uses[found] + 32'd1;
        if (cmd == CMD_SET) data[found] = v;
        else r.read_value = data[found];
      end else if (cmd == CMD_SET) begin
        if (residents >= cap) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!used[i]) continue;
            if (victim < 0 || uses[i] < uses[victim] ||
                (uses[i] == uses[victim] && rank[i] < rank[victim]))
              victim = i;
          end
          r.evicted = 1'b1;
          if (victim < 0 || uses[victim] > 1) begin
            r.evicted_key = k;
          end else begin
            r.evicted_key = keys[victim];
            for (int i = 0; i < SLOTS; i++)
              if (used[i] && rank[i] > rank[victim]) rank[i]--;
            used[victim] = 0;
            residents--;
            slot = victim;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !used[i]) slot = i;
        end
        if (slot >= 0) begin
          used[slot] = 1;
          keys[slot] = k;
          data[slot] = v;
          uses[slot] = 1;
          rank[slot] = residents;
          residents++;
        end
      end
      awaited.push_back(r);
    endfunction

    // Compare one result beat against the oldest prediction
    function void check_result(logic h, logic [31:0] rv, logic ev, logic [31:0] ek);
      lfu_result_t e;
      if (awaited.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (h !== e.hit) begin
        $error("hit: expected %0h, got %0h", e.hit, h);
        errors++;
      end
      if (rv !== e.read_value) begin
        $error("read_value: expected %0h, got %0h", e.read_value, rv);
        errors++;
      end
      if (ev !== e.evicted) begin
        $error("evicted: expected %0h, got %0h", e.evicted, ev);
        errors++;
      end
      if (ek !== e.evicted_key) begin
        $error("evicted_key: expected %0h, got %0h", e.evicted_key, ek);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;
  bit steady_flow;
  int cycles;

  lfu_req_if #(.KEY_BITS(32), .DATA_BITS(32)) req_ch ();
  lfu_rsp_if #(.KEY_BITS(32), .DATA_BITS(32)) rsp_ch ();

  lfu_scoreboard sb;

  lfu_key_value_cache_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_rsp  (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one request beat after a random gap unless in steady flow; valid stays high for the next beat
  task automatic send_request(logic cmd, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.key         <= k;
    req_ch.write_value <= v;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    sb.note_request(cmd, k, v);
  endtask

  // Drop valid so the last beat is not taken again, then wait for all results
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write capacity once the cache has gone idle
  task automatic write_capacity(logic [CAP_BITS-1:0] cap);
    drain();
    req_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(cap);
  endtask

  // Mostly recycled keys so gets hit and counts climb; some fully random
  task automatic random_phase(int n, int pool);
    logic [31:0] base;
    logic [31:0] k;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = base ^ $urandom_range(0, pool - 1);
      send_request($urandom_range(0, 1) ? CMD_SET : CMD_GET, k, $urandom);
    end
  endtask

  // Result side: stall ready at random unless in steady flow, check every beat
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      sb.check_result(rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key);
    end
  end

  initial begin
    int caps[12];
    sb = new();
    sb.errors = 0;
    sb.set_capacity(CAP_RESET);
    cycles <= 0;
    steady_flow <= 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_GET;
    req_ch.key <= '0;
    req_ch.write_value <= '0;
    rsp_ch.ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes at reset capacity: miss, inserts, hits, overwrite
    send_request(CMD_GET, 32'h0, 32'hFFFF_FFFF);
    send_request(CMD_SET, 32'h0, 32'h0);
    send_request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_GET, 32'h0, 32'h0);
    send_request(CMD_SET, 32'h0, 32'hA5A5_5A5A);
    send_request(CMD_GET, 32'h0, 32'h0);

    // Zero capacity: every set miss evicts its own key
    write_capacity(7'd0);
    send_request(CMD_SET, 32'h1234_5678, 32'h1);
    send_request(CMD_GET, 32'h1234_5678, 32'h0);

    // Capacity one: count-1 victim goes, then a hot resident forces self-eviction
    write_capacity(7'd1);
    send_request(CMD_SET, 32'hA, 32'h11);
    send_request(CMD_SET, 32'hB, 32'h22);
    send_request(CMD_GET, 32'hA, 32'h0);
    send_request(CMD_GET, 32'hB, 32'h0);
    send_request(CMD_SET, 32'hB, 32'h33);
    send_request(CMD_SET, 32'hC, 32'h44);
    send_request(CMD_GET, 32'hB, 32'h0);

    // Capacity above the slot count behaves as full size
    write_capacity(7'd127);
    send_request(CMD_SET, 32'h5, 32'h55);
    send_request(CMD_GET, 32'h5, 32'h0);

    caps = '{2, 4, 1, 8, 64, 127, 3, 16, 0, 33, 5, 96};
    foreach (caps[p]) begin
      write_capacity(CAP_BITS'(caps[p]));
      steady_flow <= (p % 3 == 2);
      random_phase(39, (caps[p] > 64 ? 64 : caps[p]) + 3);
      // Hold the sender until the cache has answered everything
      if (p == 4) drain();
      random_phase(39, (caps[p] > 64 ? 64 : caps[p]) + 3);
    end

    drain();
    req_ch.valid <= 1'b0;
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lfu_pkg.sv
rtl/core/lfu_req_if.sv
rtl/core/lfu_rsp_if.sv
rtl/core/lfu_mem.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_key_value_cache_unit.sv
verif/tb_lfu_key_value_cache_unit.sv
